// ===== design/crsst_pkg.sv =====
// Package for the clip rectangle stack span tracker.
// Holds command and result codes, word types and the control state type.
// Depends on nothing.
`timescale 1ns / 1ps

package crsst_pkg;

	localparam logic [2:0] CMD_PUSH_ROOT = 3'd0;
	localparam logic [2:0] CMD_PUSH      = 3'd1;
	localparam logic [2:0] CMD_PUSH_ISECT = 3'd2;
	localparam logic [2:0] CMD_POP       = 3'd3;
	localparam logic [2:0] CMD_CULL_RECT = 3'd4;
	localparam logic [2:0] CMD_CULL_CIRC = 3'd5;
	localparam logic [2:0] CMD_CLEAR     = 3'd6;

	localparam logic [2:0] KIND_CLIP_ADD  = 3'd0;
	localparam logic [2:0] KIND_OPQ_NEW   = 3'd1;
	localparam logic [2:0] KIND_OPQ_EXT   = 3'd2;
	localparam logic [2:0] KIND_ALP_NEW   = 3'd3;
	localparam logic [2:0] KIND_ALP_EXT   = 3'd4;
	localparam logic [2:0] KIND_POPPED    = 3'd5;
	localparam logic [2:0] KIND_CULL      = 3'd6;
	localparam logic [2:0] KIND_ERROR     = 3'd7;

	localparam int MaxResults = 4;

	typedef struct packed {
		logic [14:0]        h;
		logic [14:0]        w;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} rect_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic [14:0]        rect_w;
		logic [14:0]        rect_h;
		logic [23:0]        opaque_count;
		logic [23:0]        alpha_count;
	} req_word_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [23:0]        first_index;
		logic [23:0]        end_index;
		logic [11:0]        clip_index;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic [14:0]        out_w;
		logic [14:0]        out_h;
		logic               culled;
		logic               last;
	} rsp_word_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

endpackage

// ===== design/clip_rect_stack_span_tracker.sv =====
// Top level of the clip rectangle stack span tracker.
// Uses crsst_pkg for types and codes and crsst_cell for the stack cells.
`timescale 1ns / 1ps

//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------
//  req     | in        | req_valid/req_stall | req_word_t
//  rsp     | out       | rsp_valid/rsp_stall | rsp_word_t
//
// A command word is taken while idle, evaluated in the next cycle, and then its
// zero to four result words leave one per cycle from the result registers
// whenever rsp_stall is low, in the order in which they were packed.
// The stack is a row of cells that shift down on a push and up on a pop; the
// top rectangle always sits in the first cell.
// Reset clears the stack level, the clip table count and both span marks.
// A stall on the result side holds the current word; no new command is taken
// until the last word of the current one has been accepted.

module clip_rect_stack_span_tracker #(
	parameter int STACK_DEPTH  = 16,
	parameter int CLIP_ENTRIES = 4096,
	parameter int INDEX_BITS   = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  crsst_pkg::req_word_t  req_word,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output crsst_pkg::rsp_word_t  rsp_word
);

	localparam int LvlW = $clog2(STACK_DEPTH + 1);
	localparam int CntW = $clog2(CLIP_ENTRIES + 1);
	// Counts are taken modulo 2^INDEX_BITS; at 24 bits or more nothing is lost.
	localparam logic [23:0] IdxMask =
		(INDEX_BITS >= 24) ? 24'hFFFFFF : 24'((64'd1 << INDEX_BITS) - 64'd1);

	crsst_pkg::state_t    state_q, state_d;
	crsst_pkg::req_word_t req_s1;

	logic [LvlW-1:0]      level_q;
	crsst_pkg::rect_t     last_clip_q;
	logic [CntW-1:0]      clip_cnt_q;
	logic [23:0]          opq_end_q, alp_end_q;
	logic [CntW-1:0]      opq_clip_q, alp_clip_q;
	logic                 opq_valid_q, alp_valid_q;

	crsst_pkg::rsp_word_t res_q [crsst_pkg::MaxResults];
	logic [2:0]           res_cnt_q;
	logic [1:0]           ptr_q;

	// Stack cells; cell zero is the top of the stack.
	crsst_pkg::stack_ctl_t ctl;
	crsst_pkg::rect_t      cell_entry [STACK_DEPTH];
	crsst_pkg::rect_t      new_rect;
	crsst_pkg::rect_t      top;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		crsst_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.from_above ((i == 0) ? new_rect : cell_entry[(i == 0) ? 0 : i - 1]),
			.from_below ((i == STACK_DEPTH - 1) ? cell_entry[i]
				: cell_entry[(i == STACK_DEPTH - 1) ? i : i + 1]),
			.entry      (cell_entry[i])
		);
	end

	assign top = cell_entry[0];

	// Evaluation of the registered command.
	logic                 calc;
	logic signed [17:0]   px0, py0, px1, py1, rx0, ry0, rx1, ry1;
	logic signed [17:0]   ix0, iy0, ix1, iy1, cx_lo, cy_lo;
	logic [23:0]          oc, ac, om, am, oe, ae;
	logic                 root, to, ta, any_span, span_err, add, opq_ext, alp_ext;
	logic                 is_push, push_ok, pop_ok, culled;
	logic [CntW-1:0]      idx;
	crsst_pkg::rsp_word_t res_d [crsst_pkg::MaxResults];
	logic [2:0]           n_d;

	assign calc = (state_q == crsst_pkg::ST_CALC);

	always_comb begin
		px0 = 18'(top.x);
		py0 = 18'(top.y);
		px1 = 18'(top.x) + 18'({1'b0, top.w});
		py1 = 18'(top.y) + 18'({1'b0, top.h});
		rx0 = 18'(req_s1.rect_x);
		ry0 = 18'(req_s1.rect_y);
		rx1 = 18'(req_s1.rect_x) + 18'({1'b0, req_s1.rect_w});
		ry1 = 18'(req_s1.rect_y) + 18'({1'b0, req_s1.rect_h});
		// The circle's lower bounds use the radius in place of the height.
		cx_lo = 18'(req_s1.rect_x) - 18'({1'b0, req_s1.rect_w});
		cy_lo = 18'(req_s1.rect_y) - 18'({1'b0, req_s1.rect_w});
		ix0 = (px0 > rx0) ? px0 : rx0;
		iy0 = (py0 > ry0) ? py0 : ry0;
		ix1 = (px1 < rx1) ? px1 : rx1;
		iy1 = (py1 < ry1) ? py1 : ry1;

		new_rect.x = req_s1.rect_x;
		new_rect.y = req_s1.rect_y;
		new_rect.w = req_s1.rect_w;
		new_rect.h = req_s1.rect_h;
		if (req_s1.cmd == crsst_pkg::CMD_PUSH_ISECT && level_q != '0) begin
			if (ix0 > ix1 || iy0 > iy1) begin
				new_rect = '0;
			end else begin
				new_rect.x = ix0[15:0];
				new_rect.y = iy0[15:0];
				new_rect.w = 15'(ix1 - ix0);
				new_rect.h = 15'(iy1 - iy0);
			end
		end

		culled = 1'b0;
		if (level_q != '0) begin
			if (req_s1.cmd == crsst_pkg::CMD_CULL_RECT) begin
				culled = (rx1 < px0) || (ry1 < py0) || (px1 < rx0) || (py1 < ry0);
			end else begin
				culled = (rx1 <= px0) || (cx_lo > px1) || (rx1 - rx0 + ry0 <= py0)
					|| (cy_lo > py1);
			end
		end

		// Span closing.
		oc = req_s1.opaque_count & IdxMask;
		ac = req_s1.alpha_count & IdxMask;
		om = opq_valid_q ? opq_end_q : 24'd0;
		am = alp_valid_q ? alp_end_q : 24'd0;
		root = (req_s1.cmd == crsst_pkg::CMD_PUSH_ROOT);
		if (root) begin
			to = (oc != 24'd0) || (ac != 24'd0);
			ta = to;
		end else begin
			to = oc > om;
			ta = ac > am;
		end
		any_span = to || ta;
		add = (clip_cnt_q == '0) || (last_clip_q != top);
		span_err = any_span && ((level_q == '0)
			|| (add && clip_cnt_q >= CntW'(CLIP_ENTRIES)));
		idx = add ? clip_cnt_q : clip_cnt_q - CntW'(1);
		oe = (root && oc < om) ? om : oc;
		ae = (root && ac < am) ? am : ac;
		opq_ext = !root && opq_valid_q && (opq_clip_q == idx);
		alp_ext = !root && alp_valid_q && (alp_clip_q == idx);

		is_push = (req_s1.cmd == crsst_pkg::CMD_PUSH_ROOT)
			|| (req_s1.cmd == crsst_pkg::CMD_PUSH)
			|| (req_s1.cmd == crsst_pkg::CMD_PUSH_ISECT);
		push_ok = is_push && (level_q < LvlW'(STACK_DEPTH)) && !span_err;
		pop_ok = (req_s1.cmd == crsst_pkg::CMD_POP) && (level_q != '0) && !span_err;

		// Result words in their fixed order, packed from slot zero.
		for (int k = 0; k < crsst_pkg::MaxResults; k++) begin
			res_d[k] = '0;
		end
		n_d = 3'd0;
		if (push_ok || pop_ok) begin
			if (any_span && add) begin
				res_d[n_d[1:0]].kind = crsst_pkg::KIND_CLIP_ADD;
				res_d[n_d[1:0]].clip_index = 12'(idx);
				res_d[n_d[1:0]].out_x = top.x;
				res_d[n_d[1:0]].out_y = top.y;
				res_d[n_d[1:0]].out_w = top.w;
				res_d[n_d[1:0]].out_h = top.h;
				n_d = n_d + 3'd1;
			end
			if (to) begin
				res_d[n_d[1:0]].kind = opq_ext ? crsst_pkg::KIND_OPQ_EXT
					: crsst_pkg::KIND_OPQ_NEW;
				res_d[n_d[1:0]].first_index = om;
				res_d[n_d[1:0]].end_index = oe;
				res_d[n_d[1:0]].clip_index = 12'(idx);
				n_d = n_d + 3'd1;
			end
			if (ta) begin
				res_d[n_d[1:0]].kind = alp_ext ? crsst_pkg::KIND_ALP_EXT
					: crsst_pkg::KIND_ALP_NEW;
				res_d[n_d[1:0]].first_index = am;
				res_d[n_d[1:0]].end_index = ae;
				res_d[n_d[1:0]].clip_index = 12'(idx);
				n_d = n_d + 3'd1;
			end
			if (pop_ok) begin
				res_d[n_d[1:0]].kind = crsst_pkg::KIND_POPPED;
				res_d[n_d[1:0]].out_x = top.x;
				res_d[n_d[1:0]].out_y = top.y;
				res_d[n_d[1:0]].out_w = top.w;
				res_d[n_d[1:0]].out_h = top.h;
				n_d = n_d + 3'd1;
			end
		end else if (req_s1.cmd == crsst_pkg::CMD_CULL_RECT
			|| req_s1.cmd == crsst_pkg::CMD_CULL_CIRC) begin
			res_d[0].kind = crsst_pkg::KIND_CULL;
			res_d[0].culled = culled;
			n_d = 3'd1;
		end else if (req_s1.cmd != crsst_pkg::CMD_CLEAR) begin
			res_d[0].kind = crsst_pkg::KIND_ERROR;
			n_d = 3'd1;
		end
		if (n_d != 3'd0) begin
			res_d[2'(n_d - 3'd1)].last = 1'b1;
		end

		ctl.push = calc && push_ok;
		ctl.pop = calc && pop_ok;
	end

	// Control sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			crsst_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = crsst_pkg::ST_CALC;
				end
			end
			crsst_pkg::ST_CALC: begin
				state_d = (n_d == 3'd0) ? crsst_pkg::ST_IDLE : crsst_pkg::ST_EMIT;
			end
			crsst_pkg::ST_EMIT: begin
				if (!rsp_stall && (3'(ptr_q) + 3'd1 == res_cnt_q)) begin
					state_d = crsst_pkg::ST_IDLE;
				end
			end
			default: state_d = crsst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crsst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == crsst_pkg::ST_IDLE && req_valid) begin
			req_s1 <= req_word;
		end
		if (calc) begin
			for (int k = 0; k < crsst_pkg::MaxResults; k++) begin
				res_q[k] <= res_d[k];
			end
		end
	end

	// Block state and the result pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			last_clip_q <= '0;
			clip_cnt_q <= '0;
			opq_end_q <= '0;
			alp_end_q <= '0;
			opq_clip_q <= '0;
			alp_clip_q <= '0;
			opq_valid_q <= 1'b0;
			alp_valid_q <= 1'b0;
			res_cnt_q <= '0;
			ptr_q <= '0;
		end else if (calc) begin
			res_cnt_q <= n_d;
			ptr_q <= '0;
			if (req_s1.cmd == crsst_pkg::CMD_CLEAR) begin
				level_q <= '0;
				last_clip_q <= '0;
				clip_cnt_q <= '0;
				opq_end_q <= '0;
				alp_end_q <= '0;
				opq_clip_q <= '0;
				alp_clip_q <= '0;
				opq_valid_q <= 1'b0;
				alp_valid_q <= 1'b0;
			end else if (push_ok || pop_ok) begin
				level_q <= push_ok ? level_q + LvlW'(1) : level_q - LvlW'(1);
				if (any_span && add) begin
					clip_cnt_q <= clip_cnt_q + CntW'(1);
					last_clip_q <= top;
				end
				if (to) begin
					opq_end_q <= oe;
					opq_clip_q <= idx;
					opq_valid_q <= 1'b1;
				end
				if (ta) begin
					alp_end_q <= ae;
					alp_clip_q <= idx;
					alp_valid_q <= 1'b1;
				end
			end
		end else if (state_q == crsst_pkg::ST_EMIT && !rsp_stall) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

	assign req_stall = (state_q != crsst_pkg::ST_IDLE);
	assign rsp_valid = (state_q == crsst_pkg::ST_EMIT);
	assign rsp_word = res_q[ptr_q];

`ifndef SYNTH
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LvlW'(STACK_DEPTH))
		else $error("stack level beyond depth");
	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == crsst_pkg::ST_CALC)
		else $error("accepted command not evaluated");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && rsp_word.last |=> !rsp_valid)
		else $error("word after last result");
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp_word.last |=> rsp_valid)
		else $error("result sequence ended without last");
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.kind == crsst_pkg::KIND_ERROR |-> rsp_word.last)
		else $error("error result not final");
`endif

endmodule

// ===== design/crsst_cell.sv =====
// One cell of the clip rectangle stack: holds one rectangle.
// Depends on crsst_pkg for the rectangle and control types.
`timescale 1ns / 1ps

module crsst_cell (
	input  logic                  clk,
	input  crsst_pkg::stack_ctl_t ctl,
	input  crsst_pkg::rect_t      from_above,
	input  crsst_pkg::rect_t      from_below,
	output crsst_pkg::rect_t      entry
);

	crsst_pkg::rect_t entry_q;

	// A push moves every entry one place deeper, a pop one place up.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= from_above;
		end else if (ctl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

// ===== test/tb_clip_rect_stack_span_tracker.sv =====
// Self-checking testbench for the clip rectangle stack span tracker.
// Drives command words through a directed table and random sequences, and checks
// each result word against its own predictor. Depends on crsst_pkg and the block.
`timescale 1ns / 1ps

module tb_clip_rect_stack_span_tracker;

	localparam int DEPTH = 16;
	localparam int ENTRIES = 4096;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	// One row of the directed table. When has_exp is set, the single result word
	// is typed in by hand; otherwise the predictor supplies the expectation.
	typedef struct {
		crsst_pkg::req_word_t word;
		bit                   has_exp;
		crsst_pkg::rsp_word_t exp;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	crsst_pkg::req_word_t req_word = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	crsst_pkg::rsp_word_t rsp_word;

	// Predictor state, mirroring the block's stack, clip table and span marks.
	crsst_pkg::rect_t clip_rects[DEPTH];
	int               level;
	crsst_pkg::rect_t last_entry;
	int               entry_count;
	logic [23:0]      opq_end, alp_end;
	int               opq_clip, alp_clip;
	bit               opq_valid, alp_valid;

	crsst_pkg::rsp_word_t expected_words[$];
	bit                   typed_flags[$];
	crsst_pkg::rsp_word_t typed_words[$];
	int                   mismatches = 0;
	int                   idle_cycles = 0;
	bit                   quiet = 1'b0;
	bit                   done = 1'b0;

	dir_row_t    rows[$];
	logic [23:0] opq_cnt, alp_cnt;

	clip_rect_stack_span_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
	);

	always #5 clk = ~clk;

	function automatic crsst_pkg::rsp_word_t make_rsp(logic [2:0] kind, logic [23:0] first,
			logic [23:0] last_idx, int clip, crsst_pkg::rect_t r, bit culled);
		crsst_pkg::rsp_word_t o;
		o = '0;
		o.kind = kind;
		o.first_index = first;
		o.end_index = last_idx;
		o.clip_index = clip[11:0];
		o.out_x = r.x;
		o.out_y = r.y;
		o.out_w = r.w;
		o.out_h = r.h;
		o.culled = culled;
		return o;
	endfunction

	function automatic crsst_pkg::rsp_word_t error_word();
		crsst_pkg::rsp_word_t o;
		o = make_rsp(crsst_pkg::KIND_ERROR, 24'd0, 24'd0, 0, '0, 1'b0);
		o.last = 1'b1;
		return o;
	endfunction

	function automatic void clear_state();
		level = 0;
		last_entry = '0;
		entry_count = 0;
		opq_end = '0;
		alp_end = '0;
		opq_clip = 0;
		alp_clip = 0;
		opq_valid = 0;
		alp_valid = 0;
	endfunction

	// Closes the open opaque and alpha spans against the top clip. Returns 0 on
	// success and 1 on an error, in which case no state has changed.
	function automatic bit close_spans(logic [23:0] oc, logic [23:0] ac, bit root,
			ref crsst_pkg::rsp_word_t res[$]);
		logic [23:0] om, am, e;
		bit to, ta, add, ext;
		crsst_pkg::rect_t top;
		int idx;
		om = opq_valid ? opq_end : 24'd0;
		am = alp_valid ? alp_end : 24'd0;
		if (root) begin
			to = (oc != 24'd0) || (ac != 24'd0);
			ta = to;
		end else begin
			to = oc > om;
			ta = ac > am;
		end
		if (!to && !ta)
			return 0;
		if (level == 0)
			return 1;
		top = clip_rects[level - 1];
		add = (entry_count == 0) || (last_entry != top);
		if (add && entry_count >= ENTRIES)
			return 1;
		if (add) begin
			idx = entry_count;
			entry_count++;
			last_entry = top;
			res = {res, make_rsp(crsst_pkg::KIND_CLIP_ADD, 24'd0, 24'd0, idx, top, 1'b0)};
		end else begin
			idx = entry_count - 1;
		end
		if (to) begin
			// A push_root never lets a span end fall below its start.
			e = (root && oc < om) ? om : oc;
			ext = !root && opq_valid && opq_clip == idx;
			res = {res, make_rsp(ext ? crsst_pkg::KIND_OPQ_EXT : crsst_pkg::KIND_OPQ_NEW,
				om, e, idx, '0, 1'b0)};
			opq_end = e;
			opq_clip = idx;
			opq_valid = 1;
		end
		if (ta) begin
			e = (root && ac < am) ? am : ac;
			ext = !root && alp_valid && alp_clip == idx;
			res = {res, make_rsp(ext ? crsst_pkg::KIND_ALP_EXT : crsst_pkg::KIND_ALP_NEW,
				am, e, idx, '0, 1'b0)};
			alp_end = e;
			alp_clip = idx;
			alp_valid = 1;
		end
		return 0;
	endfunction

	// Works out every result word of one accepted command and updates the state.
	function automatic void predict_results(crsst_pkg::req_word_t w,
			ref crsst_pkg::rsp_word_t res[$]);
		crsst_pkg::rect_t r, p, s;
		int x0, y0, x1, y1, rx, ry, rw, rh, sxm, sym;
		bit c;
		rx = int'(w.rect_x);
		ry = int'(w.rect_y);
		rw = int'(w.rect_w);
		rh = int'(w.rect_h);
		r.x = w.rect_x;
		r.y = w.rect_y;
		r.w = w.rect_w;
		r.h = w.rect_h;
		case (w.cmd)
			crsst_pkg::CMD_PUSH_ROOT, crsst_pkg::CMD_PUSH, crsst_pkg::CMD_PUSH_ISECT: begin
				if (level >= DEPTH) begin
					res = {res, error_word()};
					return;
				end
				if (w.cmd == crsst_pkg::CMD_PUSH_ISECT && level > 0) begin
					p = clip_rects[level - 1];
					x0 = (int'(p.x) > rx) ? int'(p.x) : rx;
					y0 = (int'(p.y) > ry) ? int'(p.y) : ry;
					x1 = (int'(p.x) + int'(p.w) < rx + rw) ? int'(p.x) + int'(p.w) : rx + rw;
					y1 = (int'(p.y) + int'(p.h) < ry + rh) ? int'(p.y) + int'(p.h) : ry + rh;
					// An empty overlap collapses to the zero rectangle.
					if (x0 > x1 || y0 > y1) begin
						r = '0;
					end else begin
						r.x = 16'(x0);
						r.y = 16'(y0);
						r.w = 15'(x1 - x0);
						r.h = 15'(y1 - y0);
					end
				end
				if (close_spans(w.opaque_count, w.alpha_count,
						w.cmd == crsst_pkg::CMD_PUSH_ROOT, res)) begin
					res = {res, error_word()};
					return;
				end
				clip_rects[level] = r;
				level++;
			end
			crsst_pkg::CMD_POP: begin
				if (level == 0) begin
					res = {res, error_word()};
					return;
				end
				if (close_spans(w.opaque_count, w.alpha_count, 0, res)) begin
					res = {res, error_word()};
					return;
				end
				res = {res, make_rsp(crsst_pkg::KIND_POPPED, 24'd0, 24'd0, 0,
					clip_rects[level - 1], 1'b0)};
				level--;
			end
			crsst_pkg::CMD_CULL_RECT, crsst_pkg::CMD_CULL_CIRC: begin
				c = 0;
				if (level > 0) begin
					s = clip_rects[level - 1];
					sxm = int'(s.x) + int'(s.w);
					sym = int'(s.y) + int'(s.h);
					if (w.cmd == crsst_pkg::CMD_CULL_RECT) begin
						if (rx + rw < int'(s.x) || ry + rh < int'(s.y) || sxm < rx || sym < ry)
							c = 1;
					end else begin
						if (rx + rw <= int'(s.x) || rx - rw > sxm)
							c = 1;
						if (ry + rw <= int'(s.y) || ry - rw > sym)
							c = 1;
					end
				end
				res = {res, make_rsp(crsst_pkg::KIND_CULL, 24'd0, 24'd0, 0, '0, c)};
			end
			crsst_pkg::CMD_CLEAR: begin
				clear_state();
			end
			default: begin
				res = {res, error_word()};
				return;
			end
		endcase
		if (res.size() > 0)
			res[res.size() - 1].last = 1'b1;
	endfunction

	// Monitor: predicts on every accepted command word and checks every accepted
	// result word against the oldest expectation. Also runs the watchdog.
	always @(posedge clk) begin
		crsst_pkg::rsp_word_t res[$];
		crsst_pkg::rsp_word_t exp_w;
		bit typed;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				res = {};
				predict_results(req_word, res);
				typed = typed_flags.pop_front();
				exp_w = typed_words.pop_front();
				if (typed)
					expected_words = {expected_words, exp_w};
				else
					foreach (res[i])
						expected_words = {expected_words, res[i]};
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", rsp_word);
				end else begin
					exp_w = expected_words.pop_front();
					if (rsp_word !== exp_w) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result word mismatch: expected %h, got %h", exp_w, rsp_word);
					end
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT && !done) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Receiver side: stalls about a quarter of the time unless in a quiet stretch.
	always @(posedge clk)
		rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 25);

	// Presents one command word and returns at the edge where it is taken.
	task automatic send_word(crsst_pkg::req_word_t w, bit typed, crsst_pkg::rsp_word_t exp_w);
		while (!quiet && $urandom_range(99) < 25) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		typed_flags = {typed_flags, typed};
		typed_words = {typed_words, exp_w};
		req_valid <= 1'b1;
		req_word <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	function automatic crsst_pkg::req_word_t make_req(logic [2:0] cmd, int x, int y,
			int w, int h, int oc, int ac);
		crsst_pkg::req_word_t r;
		r.cmd = cmd;
		r.rect_x = 16'(x);
		r.rect_y = 16'(y);
		r.rect_w = 15'(w);
		r.rect_h = 15'(h);
		r.opaque_count = 24'(oc);
		r.alpha_count = 24'(ac);
		return r;
	endfunction

	function automatic void add_row(crsst_pkg::req_word_t w, bit has_exp,
			crsst_pkg::rsp_word_t exp_w);
		dir_row_t row;
		row.word = w;
		row.has_exp = has_exp;
		row.exp = exp_w;
		rows = {rows, row};
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(9))
			0: return -32768;
			1: return 32767;
			2: return $urandom_range(65535) - 32768;
			default: return $urandom_range(800) - 400;
		endcase
	endfunction

	function automatic int rand_size();
		case ($urandom_range(9))
			0: return 0;
			1: return 32767;
			2: return $urandom_range(32767);
			default: return $urandom_range(600);
		endcase
	endfunction

	initial begin
		crsst_pkg::rsp_word_t none, cull0;
		crsst_pkg::req_word_t w;
		int pick, n;
		logic [2:0] cmd;

		clear_state();
		foreach (clip_rects[i])
			clip_rects[i] = '0;
		none = '0;
		cull0 = make_rsp(crsst_pkg::KIND_CULL, 24'd0, 24'd0, 0, '0, 1'b0);
		cull0.last = 1'b1;

		// Directed table. Rows on an empty stack have results read off at a glance.
		add_row(make_req(crsst_pkg::CMD_POP, 0, 0, 0, 0, 0, 0), 1, error_word());
		add_row(make_req(crsst_pkg::CMD_CULL_RECT, 5, 5, 5, 5, 0, 0), 1, cull0);
		add_row(make_req(crsst_pkg::CMD_CULL_CIRC, -32768, 32767, 32767, 0, 0, 0), 1, cull0);
		add_row(make_req(CMD_UNUSED, -1, -1, 32767, 32767, 24'hFFFFFF, 24'hFFFFFF), 1,
			error_word());
		// Spans to close with no clip on the stack.
		add_row(make_req(crsst_pkg::CMD_PUSH, 0, 0, 10, 10, 5, 0), 1, error_word());
		add_row(make_req(crsst_pkg::CMD_PUSH_ISECT, -32768, -32768, 32767, 32767, 0, 0), 0,
			none);
		add_row(make_req(crsst_pkg::CMD_PUSH_ISECT, 100, 100, 50, 50, 4, 0), 0, none);
		add_row(make_req(crsst_pkg::CMD_PUSH_ISECT, 150, 150, 20, 20, 4, 3), 0, none);
		add_row(make_req(crsst_pkg::CMD_PUSH_ISECT, 500, 500, 20, 20, 9, 3), 0, none);
		add_row(make_req(crsst_pkg::CMD_CULL_RECT, 0, 0, 1, 1, 9, 3), 0, none);
		add_row(make_req(crsst_pkg::CMD_POP, 0, 0, 0, 0, 9, 3), 0, none);
		add_row(make_req(crsst_pkg::CMD_POP, 0, 0, 0, 0, 12, 8), 0, none);
		add_row(make_req(crsst_pkg::CMD_CULL_CIRC, 160, 160, 5, 0, 12, 8), 0, none);
		add_row(make_req(crsst_pkg::CMD_CULL_CIRC, 120, 120, 5, 0, 12, 8), 0, none);
		add_row(make_req(crsst_pkg::CMD_CULL_RECT, 149, 149, 1, 1, 12, 8), 0, none);
		add_row(make_req(crsst_pkg::CMD_PUSH_ROOT, 32767, 32767, 32767, 32767, 2, 1), 0, none);
		add_row(make_req(crsst_pkg::CMD_PUSH_ROOT, -32768, -32768, 0, 0, 24'hFFFFFF, 0), 0,
			none);
		add_row(make_req(crsst_pkg::CMD_PUSH, 1, 2, 3, 4, 0, 24'hFFFFFF), 0, none);
		add_row(make_req(crsst_pkg::CMD_POP, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF), 0, none);
		add_row(make_req(crsst_pkg::CMD_POP, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF), 0, none);
		add_row(make_req(crsst_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(make_req(crsst_pkg::CMD_POP, 0, 0, 0, 0, 0, 0), 1, error_word());

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_word(rows[i].word, rows[i].has_exp, rows[i].exp);

		// Random part: mostly well-formed drawing, with counts that grow between
		// clip changes, and some noise in the counts and commands.
		opq_cnt = 24'd0;
		alp_cnt = 24'd0;
		for (n = 0; n < 308; n++) begin
			quiet = (n >= 120 && n < 180);
			pick = $urandom_range(99);
			if (pick < 8)
				cmd = crsst_pkg::CMD_PUSH_ROOT;
			else if (pick < 30)
				cmd = crsst_pkg::CMD_PUSH;
			else if (pick < 48)
				cmd = crsst_pkg::CMD_PUSH_ISECT;
			else if (pick < 74)
				cmd = crsst_pkg::CMD_POP;
			else if (pick < 84)
				cmd = crsst_pkg::CMD_CULL_RECT;
			else if (pick < 94)
				cmd = crsst_pkg::CMD_CULL_CIRC;
			else if (pick < 97)
				cmd = crsst_pkg::CMD_CLEAR;
			else
				cmd = CMD_UNUSED;
			if ($urandom_range(99) < 60)
				opq_cnt = 24'(opq_cnt + $urandom_range(20));
			if ($urandom_range(99) < 50)
				alp_cnt = 24'(alp_cnt + $urandom_range(20));
			if ($urandom_range(99) < 5)
				opq_cnt = 24'($urandom_range(24'hFFFFFF));
			if ($urandom_range(99) < 5)
				alp_cnt = 24'($urandom_range(24'hFFFFFF));
			w = make_req(cmd, rand_coord(), rand_coord(), rand_size(), rand_size(),
				int'(opq_cnt), int'(alp_cnt));
			send_word(w, 0, none);
			if (cmd == crsst_pkg::CMD_CLEAR && $urandom_range(1)) begin
				opq_cnt = 24'd0;
				alp_cnt = 24'd0;
			end
		end
		quiet = 0;
		req_valid <= 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		done = 1'b1;
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
